[hdl/eida_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eida_pkg
// Shared types and constants of the entity id allocator.
// ----------------------------------------------------------------------------
package eida_pkg;

    localparam int CAPACITY = 256;
    localparam int ID_W     = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int MASK_W   = 4;

    localparam logic [CNT_W-1:0] CAP_CNT     = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(CAPACITY);

    localparam logic [2:0] OP_CREATE  = 3'd0;
    localparam logic [2:0] OP_DESTROY = 3'd1;
    localparam logic [2:0] OP_ADD     = 3'd2;
    localparam logic [2:0] OP_REMOVE  = 3'd3;
    localparam logic [2:0] OP_QUERY   = 3'd4;

    typedef struct packed {
        logic [2:0]      opcode;
        logic [ID_W-1:0] entity_id;
        logic [1:0]      component_kind;
    } t_req;

    typedef struct packed {
        logic              ok;
        logic [ID_W-1:0]   result_id;
        logic              is_active;
        logic [MASK_W-1:0] component_mask;
        logic [CNT_W-1:0]  live_count;
    } t_rsp;

endpackage
`default_nettype wire

[hdl/entity_id_allocator_with_masks_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// entity_id_allocator_with_masks_top
// Entity id allocator: LIFO free stack, fresh-id counter and per-entity
// active flag and component mask held in synchronous memories.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+------------------
//  request   | in        | i_in_valid / o_in_ready    | i_in_item (t_req)
//  response  | out       | o_out_valid / i_out_ready  | o_out_item (t_rsp)
//  config    | in        | i_cfg_we (no wait)         | i_cfg_data (limit)
//
// An item is accepted in S_IDLE, which issues the entry and stack reads;
// S_EXEC then writes back and loads the output register. The memory reads
// are registered, so the next item is taken only after write-back.
// Entries at or above the fresh-id count read as zero, so the memories
// need no clearing pass. A full output register stalls the write-back
// stage; the next item is still taken while a result waits.
// ----------------------------------------------------------------------------
module entity_id_allocator_with_masks_top (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire eida_pkg::t_req          i_in_item,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output eida_pkg::t_rsp               o_out_item,
    input  wire logic                    i_cfg_we,
    input  wire logic [eida_pkg::CNT_W-1:0] i_cfg_data
);
    import eida_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    typedef struct packed {
        logic              active;
        logic [MASK_W-1:0] mask;
    } t_entry;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_limit;
    logic [CNT_W-1:0] r_free_depth, n_free_depth;
    logic [CNT_W-1:0] r_fresh_next, n_fresh_next;
    logic [CNT_W-1:0] r_live_cnt, n_live_cnt;
    logic             r_out_valid, n_out_valid;
    t_rsp             r_out_item, n_out_item;
    t_req             r_req;

    t_entry entry_mem [CAPACITY];
    logic [ID_W-1:0] stack_mem [CAPACITY];
    t_entry          r_ent_rd;
    logic [ID_W-1:0] r_stk_rd;

    logic            ent_we;
    logic [ID_W-1:0] ent_waddr;
    t_entry          ent_wdata;
    logic            stk_we;
    logic [ID_W-1:0] stk_waddr;

    logic            in_acc;
    logic            out_acc;
    logic            do_exec;
    logic [CNT_W-1:0] eff_lim;
    logic [CNT_W-1:0] id_ext;
    logic            live;
    logic [MASK_W-1:0] bit_sel;
    logic [MASK_W-1:0] rd_mask;
    logic [ID_W-1:0] pop_addr;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_acc  = r_out_valid && i_out_ready;
    assign do_exec  = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    assign eff_lim  = (r_limit > CAP_CNT) ? CAP_CNT : r_limit;
    assign id_ext   = {1'b0, r_req.entity_id};
    // entries at or above the fresh count were never written: read as zero
    assign live     = (id_ext < eff_lim) && (id_ext < r_fresh_next) && r_ent_rd.active;
    assign rd_mask  = live ? r_ent_rd.mask : '0;
    assign bit_sel  = MASK_W'(1) << r_req.component_kind;
    assign pop_addr = ID_W'(r_free_depth - CNT_W'(1));

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            entry_mem[ent_waddr] <= ent_wdata;
        end
        if (in_acc) begin
            r_ent_rd <= entry_mem[i_in_item.entity_id];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stack_mem[stk_waddr] <= r_req.entity_id;
        end
        if (in_acc) begin
            r_stk_rd <= stack_mem[pop_addr];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_free_depth = r_free_depth;
        n_fresh_next = r_fresh_next;
        n_live_cnt   = r_live_cnt;
        n_out_valid  = r_out_valid && !out_acc;
        n_out_item   = r_out_item;
        ent_we       = 1'b0;
        ent_waddr    = r_req.entity_id;
        ent_wdata    = '0;
        stk_we       = 1'b0;
        stk_waddr    = r_free_depth[ID_W-1:0];

        if (in_acc) begin
            n_state = S_EXEC;
        end

        if (do_exec) begin
            n_state                   = S_IDLE;
            n_out_valid               = 1'b1;
            n_out_item.ok             = 1'b0;
            n_out_item.result_id      = r_req.entity_id;
            n_out_item.is_active      = live;
            n_out_item.component_mask = rd_mask;

            case (r_req.opcode)
                OP_CREATE: begin
                    n_out_item.result_id      = '0;
                    n_out_item.is_active      = 1'b0;
                    n_out_item.component_mask = '0;
                    if (r_live_cnt < eff_lim) begin
                        if (r_free_depth != '0 && r_free_depth <= CAP_CNT) begin
                            n_free_depth         = r_free_depth - CNT_W'(1);
                            ent_we               = 1'b1;
                            ent_waddr            = r_stk_rd;
                            n_out_item.result_id = r_stk_rd;
                        end else if (r_fresh_next < eff_lim) begin
                            n_fresh_next         = r_fresh_next + CNT_W'(1);
                            ent_we               = 1'b1;
                            ent_waddr            = r_fresh_next[ID_W-1:0];
                            n_out_item.result_id = r_fresh_next[ID_W-1:0];
                        end
                    end
                    if (ent_we) begin
                        ent_wdata.active     = 1'b1;
                        n_live_cnt           = r_live_cnt + CNT_W'(1);
                        n_out_item.ok        = 1'b1;
                        n_out_item.is_active = 1'b1;
                    end
                end
                OP_DESTROY: begin
                    if (live) begin
                        ent_we                    = 1'b1;
                        n_out_item.ok             = 1'b1;
                        n_out_item.is_active      = 1'b0;
                        n_out_item.component_mask = '0;
                        if (r_live_cnt != '0) begin
                            n_live_cnt = r_live_cnt - CNT_W'(1);
                        end
                        // no push once the stack holds a full limit of ids
                        if (r_free_depth < eff_lim) begin
                            stk_we       = 1'b1;
                            n_free_depth = r_free_depth + CNT_W'(1);
                        end
                    end
                end
                OP_ADD: begin
                    if (live) begin
                        ent_we                    = 1'b1;
                        ent_wdata.active          = 1'b1;
                        ent_wdata.mask            = rd_mask | bit_sel;
                        n_out_item.ok             = 1'b1;
                        n_out_item.component_mask = rd_mask | bit_sel;
                    end
                end
                OP_REMOVE: begin
                    if (live) begin
                        ent_we                    = 1'b1;
                        ent_wdata.active          = 1'b1;
                        ent_wdata.mask            = rd_mask & ~bit_sel;
                        n_out_item.ok             = 1'b1;
                        n_out_item.component_mask = rd_mask & ~bit_sel;
                    end
                end
                OP_QUERY: begin
                    n_out_item.ok = live;
                end
                default: begin
                    n_out_item.ok = 1'b0;
                end
            endcase
            n_out_item.live_count = n_live_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_limit      <= LIMIT_RESET;
            r_free_depth <= '0;
            r_fresh_next <= '0;
            r_live_cnt   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_depth <= n_free_depth;
            r_fresh_next <= n_fresh_next;
            r_live_cnt   <= n_live_cnt;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req <= i_in_item;
        end
        r_out_item <= n_out_item;
    end

`ifndef SYNTH
    // every id ever handed out is either live, on the stack, or dropped
    a_id_books: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free_depth + r_live_cnt) <= r_fresh_next)
        else $error("free depth plus live count exceeds fresh ids");

    a_fresh_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh_next <= CAP_CNT)
        else $error("fresh id counter beyond capacity");

    a_inactive_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.is_active |-> o_out_item.component_mask == '0)
        else $error("inactive id reported with a component mask");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_EXEC) && !o_in_ready)
        else $error("accepted item did not enter write-back");
`endif

endmodule
`default_nettype wire

[verif/tb_entity_id_allocator_with_masks_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_entity_id_allocator_with_masks_top
// Self-checking bench for the entity id allocator. Requests go in over a
// valid/ready channel with random gaps. A scoreboard model of the free
// stack, fresh-id counter, active flags and masks predicts each response.
// Responses are compared field by field in order. The run steps through
// several entity limits, including 1, 256 and values above the capacity.
// ----------------------------------------------------------------------------
module tb_entity_id_allocator_with_masks_top;
    import eida_pkg::*;

    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    localparam logic [1:0] KIND_MECHANIC = 2'd0;
    localparam logic [1:0] KIND_BODY     = 2'd1;
    localparam logic [1:0] KIND_PARTICLE = 2'd2;
    localparam logic [1:0] KIND_FIELD    = 2'd3;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_req                 i_in_item   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_rsp                 o_out_item;
    logic                 i_cfg_we    = 1'b0;
    logic [CNT_W-1:0]     i_cfg_data  = '0;

    // scoreboard copy of the allocator state
    bit                   live_flag     [CAPACITY];
    bit [MASK_W-1:0]      comp_mask     [CAPACITY];
    bit [ID_W-1:0]        recycle_stack [CAPACITY];
    int                   recycle_depth = 0;
    int                   fresh_id      = 0;
    int                   live_total    = 0;
    int                   id_limit      = int'(LIMIT_RESET);

    t_rsp                 rsp_due_q [$];
    t_rsp                 rsp_head;
    int                   err_count   = 0;
    bit                   idle_en     = 1'b1;
    bit                   stall_en    = 1'b1;
    int unsigned          hold_cycles = 0;

    always #1 i_clk = ~i_clk;

    entity_id_allocator_with_masks_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    function automatic int limit_in_force();
        return (id_limit > CAPACITY) ? CAPACITY : id_limit;
    endfunction

    // Updates the allocator state for one request and returns its response.
    function automatic t_rsp apply_request(input t_req req);
        t_rsp            rsp;
        int              lim;
        int              id;
        bit              live;
        bit              got;
        bit [ID_W-1:0]   nid;
        bit [MASK_W-1:0] bitm;
        lim  = limit_in_force();
        id   = int'(req.entity_id);
        live = (id < lim) && live_flag[id];
        bitm = MASK_W'(1) << req.component_kind;
        got  = 1'b0;
        nid  = '0;
        rsp  = '0;
        rsp.result_id = req.entity_id;
        if (req.opcode == OP_CREATE) begin
            rsp.result_id = '0;
            if (live_total < lim) begin
                if (recycle_depth > 0) begin
                    recycle_depth--;
                    nid = recycle_stack[recycle_depth];
                    got = 1'b1;
                end else if (fresh_id < lim) begin
                    nid = ID_W'(fresh_id);
                    fresh_id++;
                    got = 1'b1;
                end
            end
            if (got) begin
                live_total++;
                live_flag[nid] = 1'b1;
                comp_mask[nid] = '0;
                rsp.ok         = 1'b1;
                rsp.result_id  = nid;
                rsp.is_active  = 1'b1;
            end
        end else if (req.opcode == OP_DESTROY && live) begin
            live_flag[id] = 1'b0;
            comp_mask[id] = '0;
            if (live_total > 0)
                live_total--;
            // a full stack drops the id instead of recycling it
            if (recycle_depth < lim) begin
                recycle_stack[recycle_depth] = req.entity_id;
                recycle_depth++;
            end
            rsp.ok = 1'b1;
        end else if ((req.opcode == OP_ADD || req.opcode == OP_REMOVE) && live) begin
            if (req.opcode == OP_ADD)
                comp_mask[id] = comp_mask[id] | bitm;
            else
                comp_mask[id] = comp_mask[id] & ~bitm;
            rsp.ok             = 1'b1;
            rsp.is_active      = 1'b1;
            rsp.component_mask = comp_mask[id];
        end else begin
            // query, failed ops and spare opcodes
            rsp.is_active      = live;
            rsp.component_mask = live ? comp_mask[id] : '0;
            rsp.ok             = (req.opcode == OP_QUERY) ? live : 1'b0;
        end
        rsp.live_count = CNT_W'(live_total);
        return rsp;
    endfunction

    function automatic t_req make_req(input logic [2:0] op, input logic [ID_W-1:0] id,
                                      input logic [1:0] kind);
        t_req req;
        req.opcode         = op;
        req.entity_id      = id;
        req.component_kind = kind;
        return req;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] seen);
        if (seen !== want) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            err_count++;
        end
    endfunction

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_req(input t_req req);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        rsp_due_q.push_back(apply_request(req));
    endtask

    // Only while nothing is in flight.
    task automatic write_entity_limit(input logic [CNT_W-1:0] value);
        if (i_in_valid)
            i_in_valid <= 1'b0;
        while (rsp_due_q.size() != 0) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        id_limit   = int'(value);
    endtask

    task automatic test_directed();
        int k;
        int op;
        send_req(make_req(OP_QUERY, '0, KIND_MECHANIC));
        send_req(make_req(OP_DESTROY, ID_W'(CAPACITY - 1), KIND_FIELD));
        repeat (4) send_req(make_req(OP_CREATE, ID_W'(CAPACITY - 1), KIND_FIELD));
        for (k = 0; k < 4; k++)
            send_req(make_req(OP_ADD, ID_W'(3), 2'(k)));
        send_req(make_req(OP_REMOVE, ID_W'(3), KIND_BODY));
        for (op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
            send_req(make_req(3'(op), ID_W'(3), KIND_PARTICLE));
        send_req(make_req(OP_DESTROY, ID_W'(3), KIND_MECHANIC));
        send_req(make_req(OP_DESTROY, ID_W'(3), KIND_MECHANIC));
        // limit below the live count: ids 1 and 2 fall out of range
        write_entity_limit(CNT_W'(1));
        send_req(make_req(OP_DESTROY, '0, KIND_MECHANIC));
        send_req(make_req(OP_CREATE, '0, KIND_MECHANIC));
        send_req(make_req(OP_QUERY, ID_W'(2), KIND_MECHANIC));
        send_req(make_req(OP_DESTROY, ID_W'(1), KIND_MECHANIC));
        write_entity_limit(CNT_W'(3));
        send_req(make_req(OP_DESTROY, ID_W'(2), KIND_MECHANIC));
        send_req(make_req(OP_DESTROY, ID_W'(1), KIND_MECHANIC));
        // stacked id 1 lies at the new limit and is still handed out
        write_entity_limit(CNT_W'(1));
        send_req(make_req(OP_CREATE, '0, KIND_MECHANIC));
        send_req(make_req(OP_CREATE, '0, KIND_MECHANIC));
        send_req(make_req(OP_ADD, ID_W'(1), KIND_PARTICLE));
    endtask

    // Receiver holds off long enough for the block to back up its input.
    task automatic test_backpressure();
        int n;
        write_entity_limit(LIMIT_RESET);
        idle_en     = 1'b0;
        hold_cycles = 300;
        for (n = 0; n < 16; n++)
            send_req(make_req((n % 2 == 0) ? OP_CREATE : OP_QUERY, ID_W'(n), KIND_BODY));
        idle_en = 1'b1;
    endtask

    task automatic run_random(input int count);
        int              r;
        int              span;
        logic [2:0]      op;
        logic [ID_W-1:0] id;
        repeat (count) begin
            r    = $urandom_range(0, 99);
            span = (fresh_id < limit_in_force()) ? fresh_id : limit_in_force();
            if (span == 0)
                span = 1;
            // mostly ids that have been handed out and are in range
            if ($urandom_range(0, 99) < 85)
                id = ID_W'($urandom_range(0, span - 1));
            else
                id = ID_W'($urandom_range(0, CAPACITY - 1));
            if (r < 30)
                op = OP_CREATE;
            else if (r < 48)
                op = OP_DESTROY;
            else if (r < 68)
                op = OP_ADD;
            else if (r < 80)
                op = OP_REMOVE;
            else if (r < 92)
                op = OP_QUERY;
            else if (r < 95)
                op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            else begin
                op = 3'($urandom_range(OP_CREATE, OP_SPARE_LAST));
                id = ID_W'($urandom_range(0, CAPACITY - 1));
            end
            send_req(make_req(op, id, 2'($urandom_range(0, 3))));
        end
    endtask

    task automatic test_random();
        int phase_limit [8] = '{256, 8, 1, 511, 300, 2, 64, 256};
        int phase_count [8] = '{220, 140, 50, 140, 90, 60, 120, 160};
        int p;
        for (p = 0; p < 8; p++) begin
            // final phase runs flat out on both sides
            idle_en  = (p != 7) && ($urandom_range(0, 3) != 0);
            stall_en = (p != 7) && ($urandom_range(0, 3) != 0);
            write_entity_limit(CNT_W'(phase_limit[p]));
            run_random(phase_count[p]);
        end
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_cycles != 0) begin
                i_out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
                i_out_ready <= 1'b1;
            end else if (stall_en && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (rsp_due_q.size() == 0) begin
                $error("unexpected response item: %p", o_out_item);
                err_count++;
            end else begin
                rsp_head = rsp_due_q.pop_front();
                check_field("ok", 16'(rsp_head.ok), 16'(o_out_item.ok));
                check_field("result_id", 16'(rsp_head.result_id), 16'(o_out_item.result_id));
                check_field("is_active", 16'(rsp_head.is_active), 16'(o_out_item.is_active));
                check_field("component_mask", 16'(rsp_head.component_mask),
                            16'(o_out_item.component_mask));
                check_field("live_count", 16'(rsp_head.live_count),
                            16'(o_out_item.live_count));
            end
        end
    end

    initial begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random();
        i_in_valid <= 1'b0;
        while (rsp_due_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
hdl/eida_pkg.sv
hdl/entity_id_allocator_with_masks_top.sv
verif/tb_entity_id_allocator_with_masks_top.sv
